[design/tcw_pkg.sv]
package tcw_pkg;

    // default screen geometry
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // field widths
    localparam int FUNC_W   = 2;
    localparam int CHAR_W   = 8;
    localparam int COLOR_W  = 8;
    localparam int ADDR_W   = 11;
    localparam int CELL_W   = 16;
    localparam int CURSOR_W = 11;
    localparam int TAB_W    = 4;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_TAB_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_CELL = 1'b1;

    localparam logic [TAB_W-1:0]  TAB_RESET  = 4'd4;
    localparam logic [TAB_W-1:0]  TAB_MAX    = 4'd8;
    localparam logic [CELL_W-1:0] FILL_RESET = 16'h0F00;

    // function codes
    localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    // character codes
    localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'd32;

    typedef struct packed {
        logic [TAB_W-1:0]  tab_width;
        logic [CELL_W-1:0] fill_cell;
    } cfg_t;

    typedef enum logic [2:0] {
        S_WIPE,
        S_IDLE,
        S_PUT,
        S_SCROLL,
        S_FILL,
        S_READ,
        S_RWAIT,
        S_DONE
    } state_t;

endpackage

[design/tcw_screen_mem.sv]
module tcw_screen_mem #(
    parameter int DEPTH = 2000,
    parameter int IW    = 11
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [IW-1:0]             wr_addr,
    input  logic [tcw_pkg::CELL_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [IW-1:0]             rd_addr,
    output logic [tcw_pkg::CELL_W-1:0] rd_data
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] mem [DEPTH];
    logic [CELL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/tcw_seq.sv]
module tcw_seq #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    parameter int IW      = 11
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tcw_pkg::cfg_t                cfg,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [tcw_pkg::FUNC_W-1:0]   func,
    input  logic [tcw_pkg::CHAR_W-1:0]   char_code,
    input  logic [tcw_pkg::COLOR_W-1:0]  color,
    input  logic [tcw_pkg::ADDR_W-1:0]   cell_address,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [tcw_pkg::CELL_W-1:0]   cell_value,
    output logic [tcw_pkg::CURSOR_W-1:0] cursor_position,
    output logic                         mem_wr_en,
    output logic [IW-1:0]                mem_wr_addr,
    output logic [tcw_pkg::CELL_W-1:0]   mem_wr_data,
    output logic                         mem_rd_en,
    output logic [IW-1:0]                mem_rd_addr,
    input  logic [tcw_pkg::CELL_W-1:0]   mem_rd_data
);
    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int LAST  = (ROWS - 1) * COLUMNS;
    localparam int AW    = $clog2(CELLS + 1);
    localparam int RW    = $clog2(ROWS + 1);
    localparam int CLW   = $clog2(COLUMNS);
    localparam int XW    = (AW > ADDR_W) ? AW : ADDR_W;

    state_t             state_reg, state_next;
    logic [AW-1:0]      cnt_reg, cnt_next;
    logic               pend_reg, pend_next;
    logic [IW-1:0]      pend_addr_reg, pend_addr_next;
    logic [TAB_W-1:0]   tab_left_reg, tab_left_next;
    logic               ret_put_reg, ret_put_next;
    logic               wipe_item_reg, wipe_item_next;
    logic [AW-1:0]      lin_reg, lin_next;
    logic [RW-1:0]      row_reg, row_next;
    logic [CLW-1:0]     col_reg, col_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic [COLOR_W-1:0] color_reg, color_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [CELL_W-1:0]  value_reg, value_next;
    logic               out_valid_reg, out_valid_next;
    logic [CELL_W-1:0]  out_value_reg, out_value_next;
    logic [CURSOR_W-1:0] out_cursor_reg, out_cursor_next;

    logic [TAB_W-1:0]  tab_count;
    logic [CHAR_W-1:0] put_code;
    logic              addr_in_range;

    // tab width clamped into one to eight
    always_comb
    begin
        priority if (cfg.tab_width == '0)
        begin
            tab_count = TAB_W'(1);
        end
        else if (cfg.tab_width > TAB_MAX)
        begin
            tab_count = TAB_MAX;
        end
        else
        begin
            tab_count = cfg.tab_width;
        end
    end

    assign put_code      = (char_reg == CHAR_TAB) ? CHAR_SPACE : char_reg;
    assign addr_in_range = XW'(addr_reg) < XW'(CELLS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_WIPE;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            wipe_item_reg <= 1'b0;
            ret_put_reg   <= 1'b0;
            lin_reg       <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            wipe_item_reg <= wipe_item_next;
            ret_put_reg   <= ret_put_next;
            lin_reg       <= lin_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg  <= pend_addr_next;
        tab_left_reg   <= tab_left_next;
        char_reg       <= char_next;
        color_reg      <= color_next;
        addr_reg       <= addr_next;
        value_reg      <= value_next;
        out_value_reg  <= out_value_next;
        out_cursor_reg <= out_cursor_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pend_next       = pend_reg;
        pend_addr_next  = pend_addr_reg;
        tab_left_next   = tab_left_reg;
        ret_put_next    = ret_put_reg;
        wipe_item_next  = wipe_item_reg;
        lin_next        = lin_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        char_next       = char_reg;
        color_next      = color_reg;
        addr_next       = addr_reg;
        value_next      = value_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_value_next  = out_value_reg;
        out_cursor_next = out_cursor_reg;
        in_ready        = 1'b0;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = pend_addr_reg;
        mem_wr_data     = mem_rd_data;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = IW'(addr_reg);

        // pending copy write from the previous scroll read
        if (pend_reg)
        begin
            mem_wr_en = 1'b1;
        end

        unique case (state_reg)
            S_WIPE:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = cnt_reg[IW-1:0];
                mem_wr_data = '0;
                if (cnt_reg == AW'(CELLS - 1))
                begin
                    lin_next       = '0;
                    row_next       = '0;
                    col_next       = '0;
                    wipe_item_next = 1'b0;
                    state_next     = wipe_item_reg ? S_DONE : S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end

            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    char_next  = char_code;
                    color_next = color;
                    addr_next  = cell_address;
                    value_next = '0;
                    unique case (func)
                        FUNC_PUT:
                        begin
                            priority if (char_code == CHAR_NEWLINE)
                            begin
                                if (row_reg >= RW'(ROWS - 1))
                                begin
                                    ret_put_next = 1'b0;
                                    cnt_next     = '0;
                                    state_next   = S_SCROLL;
                                end
                                else
                                begin
                                    row_next   = row_reg + RW'(1);
                                    col_next   = '0;
                                    lin_next   = lin_reg - AW'(col_reg) + AW'(COLUMNS);
                                    state_next = S_DONE;
                                end
                            end
                            else if (char_code == CHAR_TAB)
                            begin
                                tab_left_next = tab_count;
                                state_next    = S_PUT;
                            end
                            else
                            begin
                                tab_left_next = TAB_W'(1);
                                state_next    = S_PUT;
                            end
                        end
                        FUNC_CLEAR:
                        begin
                            wipe_item_next = 1'b1;
                            cnt_next       = '0;
                            state_next     = S_WIPE;
                        end
                        FUNC_READ:
                        begin
                            state_next = S_READ;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_PUT:
            begin
                if (lin_reg == AW'(CELLS))
                begin
                    // end of screen: scroll, then write at the bottom row
                    ret_put_next = 1'b1;
                    cnt_next     = '0;
                    state_next   = S_SCROLL;
                end
                else
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = lin_reg[IW-1:0];
                    mem_wr_data = {color_reg, put_code};
                    lin_next    = lin_reg + AW'(1);
                    if (col_reg == CLW'(COLUMNS - 1))
                    begin
                        col_next = '0;
                        row_next = row_reg + RW'(1);
                    end
                    else
                    begin
                        col_next = col_reg + CLW'(1);
                    end
                    if (tab_left_reg > TAB_W'(1))
                    begin
                        tab_left_next = tab_left_reg - TAB_W'(1);
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_SCROLL:
            begin
                if (cnt_reg != AW'(LAST))
                begin
                    mem_rd_en      = 1'b1;
                    mem_rd_addr    = IW'(cnt_reg + AW'(COLUMNS));
                    pend_next      = 1'b1;
                    pend_addr_next = cnt_reg[IW-1:0];
                    cnt_next       = cnt_reg + AW'(1);
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_FILL;
                end
            end

            S_FILL:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = cnt_reg[IW-1:0];
                mem_wr_data = cfg.fill_cell;
                if (cnt_reg == AW'(CELLS - 1))
                begin
                    lin_next   = AW'(LAST);
                    row_next   = RW'(ROWS - 1);
                    col_next   = '0;
                    state_next = ret_put_reg ? S_PUT : S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end

            S_READ:
            begin
                mem_rd_en  = addr_in_range;
                state_next = S_RWAIT;
            end

            S_RWAIT:
            begin
                value_next = addr_in_range ? mem_rd_data : '0;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = value_reg;
                    out_cursor_next = CURSOR_W'(lin_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid       = out_valid_reg;
    assign cell_value      = out_value_reg;
    assign cursor_position = out_cursor_reg;

endmodule

[design/text_console_writer.sv]
// text console writer: a character console over a ROWS x COLUMNS screen store
// of 16-bit cells (attribute byte high, character code low) with one cursor.
// input channel (in_valid/in_ready) carries one request per beat: func selects
// put character, clear screen or read cell; char_code and color feed a put,
// cell_address feeds a read. output channel (out_valid/out_ready) returns one
// beat per request: cell_value (read data, else zero) and cursor_position.
// the config port (cfg_write/cfg_index/cfg_data) sets tab_width and fill_cell
// with no wait; write it only while the block is idle.
// work, done by the sequencer walking the screen memory:
//   a plain character writes one cell, a tab n spaces (n = tab_width held
//   to one to eight), a newline on the last row scrolls; each scroll copies
//   rows up and fills the bottom row with fill_cell (one copy or fill write
//   per cycle through the memory write port), also when a cell write meets
//   the end of screen; clear zeroes the store. one request is in work at a time.
// after reset a clearing pass zeroes the store while in_ready stays low;
// config writes are taken during it.
// the result sits in an output register: a stalled receiver holds the beat,
// and the next request may still be accepted and worked until its own result
// is ready to load.
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [tcw_pkg::FUNC_W-1:0]     func,
    input  logic [tcw_pkg::CHAR_W-1:0]     char_code,
    input  logic [tcw_pkg::COLOR_W-1:0]    color,
    input  logic [tcw_pkg::ADDR_W-1:0]     cell_address,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [tcw_pkg::CELL_W-1:0]     cell_value,
    output logic [tcw_pkg::CURSOR_W-1:0]   cursor_position,
    input  logic                           cfg_write,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tcw_pkg::*;

    // screen geometry
    localparam int CELLS = ROWS * COLUMNS;
    localparam int IW    = $clog2(CELLS);

    // configuration registers
    logic [TAB_W-1:0]  tab_width_reg;
    logic [CELL_W-1:0] fill_cell_reg;
    cfg_t              cfg;

    // memory port between sequencer and screen store
    logic              mem_wr_en;
    logic [IW-1:0]     mem_wr_addr;
    logic [CELL_W-1:0] mem_wr_data;
    logic              mem_rd_en;
    logic [IW-1:0]     mem_rd_addr;
    logic [CELL_W-1:0] mem_rd_data;

    // config writes land directly, no handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tab_width_reg <= TAB_RESET;
            fill_cell_reg <= FILL_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_TAB_WIDTH: tab_width_reg <= cfg_data[TAB_W-1:0];
                REG_FILL_CELL: fill_cell_reg <= cfg_data[CELL_W-1:0];
                default:       ;
            endcase
        end
    end

    assign cfg.tab_width = tab_width_reg;
    assign cfg.fill_cell = fill_cell_reg;

    // sequencer: cursor, scroll copy, fill, clear and read steps
    tcw_seq #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .IW      (IW)
    ) u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .char_code       (char_code),
        .color           (color),
        .cell_address    (cell_address),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .cell_value      (cell_value),
        .cursor_position (cursor_position),
        .mem_wr_en       (mem_wr_en),
        .mem_wr_addr     (mem_wr_addr),
        .mem_wr_data     (mem_wr_data),
        .mem_rd_en       (mem_rd_en),
        .mem_rd_addr     (mem_rd_addr),
        .mem_rd_data     (mem_rd_data)
    );

    // screen store, one write and one registered read per cycle
    tcw_screen_mem #(
        .DEPTH (CELLS),
        .IW    (IW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

[design/tcw_checker.sv]
module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [tcw_pkg::CELL_W-1:0]     cell_value,
    input logic [tcw_pkg::CURSOR_W-1:0]   cursor_position
);
    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam bit CURSOR_FITS = CELLS < (1 << CURSOR_W);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cell_value)
            && $stable(cursor_position))
        else $error("result beat changed while stalled");

    // one request at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted twice in a row");

    // a new result only appears out of a busy cycle
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared with no request in work");

    // cursor never runs past one beyond the last cell
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !CURSOR_FITS || (32'(cursor_position) <= 32'(CELLS)))
        else $error("cursor past end of screen");

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .cell_value      (cell_value),
    .cursor_position (cursor_position)
);
